### rtl/core/harmonic_max_pool_sum_defines.svh
// assertion macros for the harmonic max-pool sum block
// expects clk and rst_n in the scope of use
`ifndef HARMONIC_MAX_POOL_SUM_DEFINES_SVH
`define HARMONIC_MAX_POOL_SUM_DEFINES_SVH

// same-cycle implication
`define HMPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hmps_pkg.sv
// shared types and constants for the harmonic max-pool sum block
// no dependencies
`timescale 1ns / 1ps

package hmps_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 9;
  localparam int BIN_W       = 7;
  localparam int SUM_W       = 40;
  localparam int ACC_W       = 42;
  localparam int PROD_W      = 32;
  localparam int COUNT_W     = 3;
  localparam int HARM_W      = 3;
  localparam int NUM_WEIGHTS = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 48;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HARM_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FOUR  = 3'd4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] hmps_weight_t;

  typedef struct packed {
    logic              wr;
    logic              start;
    logic              rd;
    logic [HARM_W-1:0] k;
    logic              mul;
    logic [HARM_W-1:0] harm;
    logic              acc;
    logic              load_out;
  } hmps_cmd_t;

  typedef struct packed {
    logic out_free;
  } hmps_status_t;

endpackage

### rtl/core/harmonic_max_pool_sum.sv
// channel   dir  tdata / tuser contents (lsb first)
// in        in   tdata: sample_index 9, sample_value 16, bin_index 7, prior_sum 40; tuser: op
// out       out  tdata: bin_sum 40, bin_echo 7, zero pad 1
// cfg       in   cfg_index 3, cfg_data 16
//
// a sample write is taken while idle and leaves the block ready; a compute word reads
// the pooled store positions one at a time through the single store read port and does
// one multiply-accumulate per harmonic. in_tready is low while a compute word is in work.
// a finished result waits in the output register; the next word is taken meanwhile.
// synchronous active-low reset; the sample store is not cleared.
// top level: config registers, controller and datapath; depends on hmps_pkg
`timescale 1ns / 1ps
`include "harmonic_max_pool_sum_defines.svh"

module harmonic_max_pool_sum #(
  parameter int NUM_BINS      = 128,
  parameter int MAX_HARMONICS = 4,
  parameter int STORE_DEPTH   = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample_index, sample_value, bin_index, prior_sum
  input  logic [hmps_pkg::IN_DATA_W-1:0]       in_tdata,
  // op
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // bin_sum, bin_echo
  output logic [hmps_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hmps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hmps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hmps_pkg::*;

  logic [COUNT_W-1:0]          harm_count_r;
  logic [COUNT_W-1:0]          count_eff;
  hmps_weight_t                weight_r [NUM_WEIGHTS];
  logic                        bin_ok;
  hmps_cmd_t                   cmd;
  hmps_status_t                st;
  logic [IDX_W-1:0]            in_sample_index;
  logic signed [SAMPLE_W-1:0]  in_sample_value;
  logic [BIN_W-1:0]            in_bin_index;
  logic signed [SUM_W-1:0]     in_prior_sum;
  logic signed [SUM_W-1:0]     out_bin_sum;
  logic [BIN_W-1:0]            out_bin_echo;

  assign in_sample_index = in_tdata[8:0];
  assign in_sample_value = in_tdata[24:9];
  assign in_bin_index    = in_tdata[31:25];
  assign in_prior_sum    = in_tdata[71:32];
  assign out_tdata       = {1'b0, out_bin_echo, out_bin_sum};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      harm_count_r <= COUNT_W'(4);
      weight_r[0]  <= SAMPLE_W'(0);
      weight_r[1]  <= SAMPLE_W'(1);
      weight_r[2]  <= SAMPLE_W'(1);
      weight_r[3]  <= SAMPLE_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HARM_COUNT:   harm_count_r <= cfg_data[COUNT_W-1:0];
        CFG_WEIGHT_ONE:   weight_r[0]  <= cfg_data;
        CFG_WEIGHT_TWO:   weight_r[1]  <= cfg_data;
        CFG_WEIGHT_THREE: weight_r[2]  <= cfg_data;
        CFG_WEIGHT_FOUR:  weight_r[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign count_eff = (32'(harm_count_r) > MAX_HARMONICS) ? COUNT_W'(MAX_HARMONICS)
                                                          : harm_count_r;
  assign bin_ok    = (32'(in_bin_index) < NUM_BINS);

  hmps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .bin_ok    (bin_ok),
    .count     (count_eff),
    .st        (st),
    .cmd       (cmd)
  );

  hmps_datapath #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_HARMONICS (MAX_HARMONICS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_bin_index    (in_bin_index),
    .in_prior_sum    (in_prior_sum),
    .weights         (weight_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_bin_sum     (out_bin_sum),
    .out_bin_echo    (out_bin_echo)
  );

  `HMPS_ASSERT_NXT(a_busy_after_compute,
                   in_tvalid && in_tready && (in_tuser == OP_COMPUTE) && bin_ok,
                   !in_tready, "compute word did not make the block busy")
  `HMPS_ASSERT_NOW(a_result_after_busy, $rose(out_tvalid), !$past(in_tready),
                   "result appeared without a compute in work")
  `HMPS_ASSERT_NOW(a_bin_in_range, out_tvalid, 32'(out_bin_echo) < NUM_BINS,
                   "result for a bin out of range")

endmodule

### rtl/core/hmps_ctrl.sv
// sequencer for the harmonic max-pool sum block
// depends on hmps_pkg
`timescale 1ns / 1ps

module hmps_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_op,
  input  logic                          bin_ok,
  input  logic [hmps_pkg::COUNT_W-1:0]  count,
  input  hmps_pkg::hmps_status_t        st,
  output hmps_pkg::hmps_cmd_t           cmd
);
  import hmps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_DRAIN,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [HARM_W-1:0]   h_r, h_nxt;
  logic [HARM_W-1:0]   k_r, k_nxt;
  logic [COUNT_W-1:0]  last_h;

  assign in_tready = (state_r == S_IDLE);
  assign last_h    = count - COUNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.harm  = h_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else if (bin_ok) begin
            cmd.start = 1'b1;
            h_nxt     = '0;
            k_nxt     = '0;
            state_nxt = (count == '0) ? S_DONE : S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        if (k_r == h_r) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + HARM_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (h_r == HARM_W'(last_h)) begin
          state_nxt = S_DONE;
        end else begin
          h_nxt     = h_r + HARM_W'(1);
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/core/hmps_datapath.sv
// sample store, max pooling, weighting, accumulation and result register
// depends on hmps_pkg
`timescale 1ns / 1ps

module hmps_datapath #(
  parameter int STORE_DEPTH   = 512,
  parameter int MAX_HARMONICS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hmps_pkg::hmps_cmd_t                  cmd,
  output hmps_pkg::hmps_status_t               st,
  input  logic [hmps_pkg::IDX_W-1:0]           in_sample_index,
  input  logic signed [hmps_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [hmps_pkg::BIN_W-1:0]           in_bin_index,
  input  logic signed [hmps_pkg::SUM_W-1:0]    in_prior_sum,
  input  hmps_pkg::hmps_weight_t               weights [hmps_pkg::NUM_WEIGHTS],
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic signed [hmps_pkg::SUM_W-1:0]    out_bin_sum,
  output logic [hmps_pkg::BIN_W-1:0]           out_bin_echo
);
  import hmps_pkg::*;

  localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int POS_W     = $clog2(MAX_HARMONICS << BIN_W);
  localparam int RED_W     = (POS_W > IDX_W) ? POS_W : IDX_W;
  localparam int MOD_STEPS = (RED_W >= ADDR_W) ? (RED_W - ADDR_W + 1) : 1;

  function automatic logic [RED_W-1:0] wrap_pos(input logic [RED_W-1:0] v);
    logic [RED_W-1:0] r;
    r = v;
    for (int s = MOD_STEPS - 1; s >= 0; s--) begin
      if (32'(r) >= (STORE_DEPTH << s)) begin
        r = r - RED_W'(STORE_DEPTH << s);
      end
    end
    return r;
  endfunction

  logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_valid_r;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;
  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           base_r, base_nxt;
  logic [BIN_W-1:0]           bin_r;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  hmps_weight_t               weight_sel;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [SUM_W-1:0]    sat_sum;
  logic                       out_valid_r;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic [BIN_W-1:0]           out_bin_r;

  assign pos     = base_r + POS_W'(cmd.k);
  assign rd_addr = ADDR_W'(wrap_pos(RED_W'(pos)));
  assign wr_addr = ADDR_W'(wrap_pos(RED_W'(in_sample_index)));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store_mem[wr_addr] <= in_sample_value;
    end
    if (cmd.rd) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // running max, floored at zero
  always_comb begin
    max_nxt = max_r;
    if (cmd.start || cmd.acc) begin
      max_nxt = '0;
    end else if (rd_valid_r && (rd_data_r > max_r)) begin
      max_nxt = rd_data_r;
    end
  end

  assign weight_sel = (32'(cmd.harm) < NUM_WEIGHTS) ? weights[cmd.harm[1:0]] : '0;
  assign prod_nxt   = max_r * weight_sel;

  always_comb begin
    acc_nxt  = acc_r;
    base_nxt = base_r;
    if (cmd.start) begin
      acc_nxt  = ACC_W'(in_prior_sum);
      base_nxt = POS_W'(in_bin_index);
    end else if (cmd.acc) begin
      acc_nxt  = acc_r + ACC_W'(prod_r);
      base_nxt = base_r + POS_W'(bin_r);
    end
  end

  always_comb begin
    if ((&acc_r[ACC_W-1:SUM_W-1]) || !(|acc_r[ACC_W-1:SUM_W-1])) begin
      sat_sum = acc_r[SUM_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_sum = SUM_MIN;
    end else begin
      sat_sum = SUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    max_r  <= max_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    if (cmd.start) begin
      bin_r <= in_bin_index;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.load_out) begin
      out_sum_r <= sat_sum;
      out_bin_r <= bin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.out_free  = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_bin_sum  = out_sum_r;
  assign out_bin_echo = out_bin_r;

endmodule

### tb/testbench.sv
// self-checking bench for harmonic_max_pool_sum: loads samples, computes bins and
// checks each bin_sum / bin_echo word against an in-bench predictor of the block
// depends on hmps_pkg and the harmonic_max_pool_sum rtl
`timescale 1ns / 1ps

module testbench;
  import hmps_pkg::*;

  localparam int STORE_DEPTH   = 512;
  localparam int NUM_BINS      = 128;
  localparam int MAX_HARMONICS = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 250;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic [BIN_W-1:0] bin;
  } bin_result_t;

  class bin_sum_scoreboard;
    logic signed [SAMPLE_W-1:0] samples [STORE_DEPTH];
    logic [COUNT_W-1:0]         harm_count;
    logic signed [SAMPLE_W-1:0] weights [NUM_WEIGHTS];
    bin_result_t                due [$];
    int                         errors;

    function new();
      harm_count = 3'd4;
      weights    = '{16'sd0, 16'sd1, 16'sd1, 16'sd1};
      errors     = 0;
      foreach (samples[i]) samples[i] = '0;
    endfunction

    function int active_harmonics();
      return (harm_count > MAX_HARMONICS) ? MAX_HARMONICS : int'(harm_count);
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_HARM_COUNT:   harm_count = value[COUNT_W-1:0];
        CFG_WEIGHT_ONE:   weights[0] = value;
        CFG_WEIGHT_TWO:   weights[1] = value;
        CFG_WEIGHT_THREE: weights[2] = value;
        CFG_WEIGHT_FOUR:  weights[3] = value;
        default: ;
      endcase
    endfunction

    // accepted input word: store update or expected bin sum
    function void note_word(logic op, logic [IN_DATA_W-1:0] data);
      logic signed [SUM_W-1:0] prior;
      longint acc;
      longint peak;
      longint s;
      int b;
      bin_result_t r;
      if (op == OP_WRITE) begin
        samples[data[8:0]] = data[24:9];
        return;
      end
      b = int'(data[31:25]);
      prior = data[71:32];
      acc = longint'(prior);
      for (int h = 1; h <= active_harmonics(); h++) begin
        peak = 0;
        for (int k = 0; k < h; k++) begin
          s = longint'(samples[(h * b + k) % STORE_DEPTH]);
          if (s > peak) peak = s;
        end
        acc += peak * longint'(weights[h-1]);
      end
      if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
      r.sum = acc[SUM_W-1:0];
      r.bin = b[BIN_W-1:0];
      due.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] word);
      bin_result_t r;
      if (due.size() == 0) begin
        report($sformatf("result word %h with nothing expected", word));
        return;
      end
      r = due.pop_front();
      if (word[39:0] !== r.sum)
        report($sformatf("bin %0d: bin_sum %h, expected %h", r.bin, word[39:0], r.sum));
      if (word[46:40] !== r.bin)
        report($sformatf("bin_echo %0d, expected %0d", word[46:40], r.bin));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic [IN_DATA_W-1:0]     in_tdata;
  logic                     in_tuser;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [OUT_DATA_W-1:0]    out_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  bin_sum_scoreboard sb = new();
  bit [STORE_DEPTH-1:0] sample_seen;
  bit steady;
  int still_cycles = 0;

  harmonic_max_pool_sum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),    // sample_index, sample_value, bin_index, prior_sum
    .in_tuser   (in_tuser),    // op
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),   // bin_sum, bin_echo, pad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_word(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      still_cycles <= 0;
    else
      still_cycles <= still_cycles + 1;
  end

  initial begin
    while (still_cycles < STALL_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic push_word(input logic op, input logic [IN_DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic issue_write(input int pos, input logic [SAMPLE_W-1:0] value);
    sample_seen[pos] = 1'b1;
    push_word(OP_WRITE, {40'd0, 7'd0, value, pos[IDX_W-1:0]});
  endtask

  task automatic issue_compute(input int b, input logic [SUM_W-1:0] prior);
    push_word(OP_COMPUTE, {prior, b[BIN_W-1:0], 16'd0, 9'd0});
  endtask

  // drained and settled before any register write
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(input logic [COUNT_W-1:0] count, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] w3,
                           input logic [15:0] w4);
    logic [CFG_DATA_W-1:0] upper;
    upper = CFG_DATA_W'($urandom);
    write_register(CFG_HARM_COUNT, {upper[15:3], count});
    write_register(CFG_WEIGHT_ONE, w1);
    write_register(CFG_WEIGHT_TWO, w2);
    write_register(CFG_WEIGHT_THREE, w3);
    write_register(CFG_WEIGHT_FOUR, w4);
  endtask

  // first store position the bin reads that was never written, else -1
  function automatic int missing_sample(int b);
    for (int h = 1; h <= sb.active_harmonics(); h++)
      for (int k = 0; k < h; k++)
        if (!sample_seen[(h * b + k) % STORE_DEPTH]) return (h * b + k) % STORE_DEPTH;
    return -1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_prior();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return SUM_MAX - $urandom;
      1: return SUM_MIN + $urandom;
      default: return raw[SUM_W-1:0];
    endcase
  endfunction

  task automatic random_words(input int n);
    int b;
    int m;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) begin
        issue_write($urandom_range(STORE_DEPTH - 1), pick_sample());
      end else begin
        b = $urandom_range(NUM_BINS - 1);
        m = missing_sample(b);
        if (m >= 0) issue_write(m, pick_sample());
        else issue_compute(b, pick_prior());
      end
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] seed_vals [8];
    seed_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                  16'hffff, 16'h3039, 16'h7fff, 16'hfffe};
    sample_seen = '0;
    steady     = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset weights, then overlarge count with max weights, min weights,
    // zero count; sums pushed into both saturation rails
    for (int i = 0; i < 8; i++) issue_write(i, seed_vals[i]);
    issue_compute(0, 40'd0);
    issue_compute(1, SUM_MAX);
    issue_compute(1, SUM_MIN);
    issue_compute(0, {SUM_W{1'b1}});
    set_phase(3'd7, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    issue_compute(1, SUM_MAX - 5);
    issue_compute(0, 40'd0);
    set_phase(3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    issue_compute(1, SUM_MIN + 5);
    issue_write(STORE_DEPTH - 1, 16'h8000);
    issue_compute(1, 40'd0);
    set_phase(3'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    issue_compute(1, pick_prior());
    issue_compute(0, SUM_MAX);

    set_phase(3'd4, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_words(PHASE_WORDS);
    steady = 1'b1;
    set_phase(3'd4, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    random_words(PHASE_WORDS);
    steady = 1'b0;
    set_phase(3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    random_words(PHASE_WORDS);
    set_phase(COUNT_W'($urandom_range(7)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    random_words(PHASE_WORDS);
    set_phase(3'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_words(PHASE_WORDS);
    set_phase(COUNT_W'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    random_words(PHASE_WORDS);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
